// ===== rtl/core/iso_adaptive_sharpen_denoise_defines.svh =====
// Assertion macros shared by the sharpen and denoise block.
`ifndef ISO_ADAPTIVE_SHARPEN_DENOISE_DEFINES_SVH
`define ISO_ADAPTIVE_SHARPEN_DENOISE_DEFINES_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define ISD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define ISD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/isd_pkg.sv =====
// Shared types and constants of the ISO adaptive sharpen and denoise block.
package isd_pkg;
	localparam int MAX_WIDTH = 8192;
	localparam int AW        = $clog2(MAX_WIDTH);
	localparam int WW        = AW + 1;
	localparam int CH_W      = 16;
	localparam int NUM_LANES = 3;
	localparam int PX_W      = CH_W * NUM_LANES;

	localparam logic [19:0] ISO_SHARPEN_LIMIT = 20'd800;
	localparam logic [19:0] ISO_STRONG_MIN    = 20'd3200;
	localparam logic [14:0] BLEND_LIGHT       = 15'd13107;
	localparam logic [14:0] BLEND_STRONG      = 15'd24904;
	localparam logic [13:0] SHARP_GAIN        = 14'd11796;

	typedef enum logic [1:0] {
		MODE_BYPASS  = 2'd0,
		MODE_SHARPEN = 2'd1,
		MODE_LIGHT   = 2'd2,
		MODE_STRONG  = 2'd3
	} mode_t;

	localparam logic [1:0] APPLIED_BYPASS    = 2'd0;
	localparam logic [1:0] APPLIED_SHARPENED = 2'd1;
	localparam logic [1:0] APPLIED_SMOOTHED  = 2'd2;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	localparam logic [1:0] CFG_ISO    = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	typedef struct packed {
		logic shp_load;
		logic heavy_blend;
	} lane_ctl_t;
endpackage

// ===== rtl/core/isd_lane.sv =====
// One color channel lane: recursive blend and registered unsharp-mask arithmetic.
module isd_lane import isd_pkg::*; (
	input  logic            clk,
	input  lane_ctl_t       ctl,
	input  logic [CH_W-1:0] blend_p,
	input  logic [CH_W-1:0] blend_q,
	output logic [CH_W-1:0] blend_out,
	input  logic [CH_W-1:0] centre,
	input  logic [CH_W-1:0] up,
	input  logic [CH_W-1:0] left,
	input  logic [CH_W-1:0] right,
	input  logic [CH_W-1:0] down,
	output logic [CH_W-1:0] sharp_out
);
	logic [14:0]        coef;
	logic signed [16:0] diff;
	logic signed [32:0] bprod;
	logic signed [16:0] bstep;
	logic signed [17:0] bsum;

	logic [17:0]        nsum;
	logic signed [18:0] lap;
	logic signed [33:0] prod_s1;
	logic [CH_W-1:0]    centre_s1;
	logic signed [36:0] num;
	logic [17:0]        hi;

	// p + floor(B*(q-p)/65536) equals the weighted Q16 mix of p and q.
	always_comb begin
		coef      = ctl.heavy_blend ? BLEND_STRONG : BLEND_LIGHT;
		diff      = $signed({1'b0, blend_q}) - $signed({1'b0, blend_p});
		bprod     = diff * $signed({1'b0, coef});
		bstep     = bprod[32:16];
		bsum      = $signed({2'b00, blend_p}) + $signed({bstep[16], bstep});
		blend_out = bsum[CH_W-1:0];
	end

	always_comb begin
		nsum = {2'b00, up} + {2'b00, left} + {2'b00, right} + {2'b00, down};
		lap  = $signed({1'b0, centre, 2'b00}) - $signed({1'b0, nsum});
	end

	always_ff @(posedge clk) begin
		if (ctl.shp_load) begin
			prod_s1   <= lap * $signed({1'b0, SHARP_GAIN});
			centre_s1 <= centre;
		end
	end

	always_comb begin
		num = $signed({2'b00, centre_s1, 19'd0}) + $signed({{3{prod_s1[33]}}, prod_s1});
		hi  = num[36:19];
		if (num[36])
			sharp_out = '0;
		else if (hi[17:16] != 2'b00)
			sharp_out = '1;
		else
			sharp_out = hi[CH_W-1:0];
	end
endmodule

// ===== rtl/core/iso_adaptive_sharpen_denoise.sv =====
// ISO adaptive sharpen / denoise stage for a 16-bit RGB raster, top level.
// Pixels enter in row order and leave one row late; a flush transaction emits one
// pending pixel. With a pixel pending, a flush or a pixel runs three serial reads of
// the output row buffer that fetch the left, center and right samples for the sharpen
// lanes; with nothing pending the reads are skipped, and a stalled output holds the
// block in its emit state until taken. The pixel that closes a row adds a row sweep
// that walks the line buffers from the last column down to column 0, one entry per
// cycle, to copy rows or run the right-to-left smoothing pass. The three channels are
// processed by parallel lanes and merged into one output register, so a finished
// result may wait while the next transaction is taken.
`include "iso_adaptive_sharpen_denoise_defines.svh"
module iso_adaptive_sharpen_denoise import isd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [PX_W-1:0] s_axis_tdata,   // pixel_ch0, pixel_ch1, pixel_ch2
	input  logic            s_axis_tuser,   // op
	output logic            m_axis_tvalid,
	input  logic            m_axis_tready,
	output logic [PX_W-1:0] m_axis_tdata,   // out_ch0, out_ch1, out_ch2
	output logic            m_axis_tlast,
	output logic [2:0]      m_axis_tuser,   // frame_end, mode_applied
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [19:0]     cfg_data
);
	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_PIX   = 11'b00000000010,
		ST_EMK   = 11'b00000000100,
		ST_RD0   = 11'b00000001000,
		ST_RD1   = 11'b00000010000,
		ST_RD2   = 11'b00000100000,
		ST_CAP   = 11'b00001000000,
		ST_EMIT  = 11'b00010000000,
		ST_ROW   = 11'b00100000000,
		ST_SWEEP = 11'b01000000000,
		ST_SWEND = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [19:0] iso_q;
	logic [13:0] fw_q;
	logic [15:0] fh_q;

	logic [WW-1:0] w;
	logic [15:0]   h;

	logic            op_q;
	logic [PX_W-1:0] px_q;
	logic [AW-1:0]   col_q;
	logic [AW-1:0]   colcnt_q;
	logic [15:0]     rowcnt_q;
	logic [WW-1:0]   pc_q;
	logic [AW-1:0]   k_q;
	mode_t           active_q;
	mode_t           emit_mode_q;
	logic [PX_W-1:0] carry_q;
	logic [PX_W-1:0] prev_q;
	logic [PX_W-1:0] c_q, u_q, l_q, dn_q;

	logic [AW-1:0]   sw_i_q;
	logic            sw_v_s1;
	logic [AW-1:0]   sw_a_s1;

	logic [PX_W-1:0] above_mem [MAX_WIDTH];
	logic [PX_W-1:0] mid_mem [MAX_WIDTH];
	logic [PX_W-1:0] pend_mem [MAX_WIDTH];
	logic [PX_W-1:0] a_rd, m_rd, p_rd;
	logic [AW-1:0]   a_raddr, m_raddr, p_raddr;
	logic            m_we, p_we, a_we;
	logic [AW-1:0]   m_waddr, p_waddr;
	logic [PX_W-1:0] m_wdata, p_wdata;

	logic            out_valid_q;
	logic [PX_W-1:0] out_data_q;
	logic            out_last_q;
	logic [2:0]      out_user_q;

	lane_ctl_t       lctl;
	logic [PX_W-1:0] bl_p, bl_q, bl_out, sh_out;
	logic [PX_W-1:0] px_new, sweep_val;

	logic in_fire, out_load, sharp_cond, row_done;
	logic [WW-1:0] pc_clamp;
	logic [16:0]   row_next;
	mode_t         mode_sel;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_load      = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready);

	always_comb begin
		if (fw_q == 14'd0)
			w = WW'(1);
		else if (32'(fw_q) > 32'(MAX_WIDTH))
			w = WW'(MAX_WIDTH);
		else
			w = WW'(fw_q);
		h        = (fh_q == 16'd0) ? 16'd1 : fh_q;
		pc_clamp = (pc_q > w) ? w : pc_q;
		row_done = ({1'b0, col_q} + WW'(1)) >= w;
		row_next = {1'b0, rowcnt_q} + 17'd1;
		sharp_cond = (emit_mode_q == MODE_SHARPEN) && (rowcnt_q >= 16'd2) && (k_q != '0)
			&& (({1'b0, k_q} + WW'(1)) < w);
		if (iso_q == 20'd0 || fw_q < 14'd3 || fh_q < 16'd3)
			mode_sel = MODE_BYPASS;
		else if (iso_q < ISO_SHARPEN_LIMIT)
			mode_sel = MODE_SHARPEN;
		else if (iso_q < ISO_STRONG_MIN)
			mode_sel = MODE_LIGHT;
		else
			mode_sel = MODE_STRONG;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_q <= '0;
			fw_q  <= '0;
			fh_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ISO:    iso_q <= cfg_data;
				CFG_WIDTH:  fw_q  <= cfg_data[13:0];
				CFG_HEIGHT: fh_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Channel lanes.
	assign lctl.shp_load    = (state_q == ST_CAP);
	assign lctl.heavy_blend = (active_q == MODE_STRONG);
	assign bl_p             = (state_q == ST_PIX) ? px_q : m_rd;
	assign bl_q             = (state_q == ST_PIX) ? carry_q : prev_q;

	for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
		isd_lane u_lane (
			.clk       (clk),
			.ctl       (lctl),
			.blend_p   (bl_p[g*CH_W +: CH_W]),
			.blend_q   (bl_q[g*CH_W +: CH_W]),
			.blend_out (bl_out[g*CH_W +: CH_W]),
			.centre    (c_q[g*CH_W +: CH_W]),
			.up        (u_q[g*CH_W +: CH_W]),
			.left      (l_q[g*CH_W +: CH_W]),
			.right     (p_rd[g*CH_W +: CH_W]),
			.down      (dn_q[g*CH_W +: CH_W]),
			.sharp_out (sh_out[g*CH_W +: CH_W])
		);
	end

	always_comb begin
		px_new = ((active_q == MODE_LIGHT || active_q == MODE_STRONG) && col_q != '0)
			? bl_out : px_q;
		sweep_val = ({1'b0, sw_a_s1} + WW'(1) == w) ? m_rd : bl_out;
	end

	// Memory port selection.
	always_comb begin
		m_we    = (state_q == ST_PIX);
		m_waddr = col_q;
		m_wdata = px_new;
		p_we    = sw_v_s1;
		p_waddr = sw_a_s1;
		a_we    = sw_v_s1 && (active_q == MODE_SHARPEN);
		case (active_q) inside
			MODE_LIGHT, MODE_STRONG: p_wdata = sweep_val;
			default:                 p_wdata = m_rd;
		endcase
		a_raddr = k_q;
		m_raddr = (state_q == ST_SWEEP) ? sw_i_q : k_q;
		case (state_q)
			ST_RD1:   p_raddr = k_q - AW'(1);
			ST_RD2:   p_raddr = k_q + AW'(1);
			ST_SWEEP: p_raddr = sw_i_q;
			default:  p_raddr = k_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (a_we)
			above_mem[sw_a_s1] <= p_rd;
		a_rd <= above_mem[a_raddr];
	end

	always_ff @(posedge clk) begin
		if (m_we)
			mid_mem[m_waddr] <= m_wdata;
		m_rd <= mid_mem[m_raddr];
	end

	always_ff @(posedge clk) begin
		if (p_we)
			pend_mem[p_waddr] <= p_wdata;
		p_rd <= pend_mem[p_raddr];
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q  <= s_axis_tuser;
			px_q  <= s_axis_tdata;
			col_q <= ({1'b0, colcnt_q} >= w) ? AW'(w - WW'(1)) : colcnt_q;
		end
		if (state_q == ST_PIX && (active_q == MODE_LIGHT || active_q == MODE_STRONG))
			carry_q <= px_new;
		if (state_q == ST_RD1) begin
			c_q  <= p_rd;
			u_q  <= a_rd;
			dn_q <= m_rd;
		end
		if (state_q == ST_RD2)
			l_q <= p_rd;
		if (sw_v_s1)
			prev_q <= sweep_val;
		if (state_q == ST_EMK)
			k_q <= AW'(w - pc_clamp);
		sw_a_s1 <= sw_i_q;
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			colcnt_q    <= '0;
			rowcnt_q    <= '0;
			pc_q        <= '0;
			active_q    <= MODE_BYPASS;
			emit_mode_q <= MODE_BYPASS;
			sw_i_q      <= '0;
			sw_v_s1     <= 1'b0;
		end else begin
			sw_v_s1 <= (state_q == ST_SWEEP);
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (s_axis_tuser == OP_FLUSH) begin
							state_q <= ST_EMK;
						end else begin
							if (colcnt_q == '0 && rowcnt_q == 16'd0)
								active_q <= mode_sel;
							state_q <= ST_PIX;
						end
					end
				end
				ST_PIX: state_q <= ST_EMK;
				ST_EMK: begin
					if (pc_q == '0) begin
						state_q <= ST_ROW;
					end else begin
						pc_q    <= pc_clamp;
						state_q <= ST_RD0;
					end
				end
				ST_RD0: state_q <= ST_RD1;
				ST_RD1: state_q <= ST_RD2;
				ST_RD2: state_q <= ST_CAP;
				ST_CAP: state_q <= ST_EMIT;
				ST_EMIT: begin
					if (out_load) begin
						pc_q    <= pc_q - WW'(1);
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					if (op_q == OP_FLUSH) begin
						state_q <= ST_IDLE;
					end else if (row_done) begin
						sw_i_q  <= AW'(w - WW'(1));
						state_q <= ST_SWEEP;
					end else begin
						colcnt_q <= col_q + AW'(1);
						state_q  <= ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (sw_i_q == '0)
						state_q <= ST_SWEND;
					else
						sw_i_q <= sw_i_q - AW'(1);
				end
				ST_SWEND: begin
					pc_q        <= w;
					emit_mode_q <= active_q;
					colcnt_q    <= '0;
					rowcnt_q    <= (row_next >= {1'b0, h}) ? 16'd0 : row_next[15:0];
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register merging the lane results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q    <= sharp_cond ? sh_out : c_q;
			out_last_q    <= ({1'b0, k_q} + WW'(1) == w);
			out_user_q[0] <= ({1'b0, k_q} + WW'(1) == w) && (rowcnt_q == 16'd0);
			case (emit_mode_q) inside
				MODE_SHARPEN:            out_user_q[2:1] <= APPLIED_SHARPENED;
				MODE_LIGHT, MODE_STRONG: out_user_q[2:1] <= APPLIED_SMOOTHED;
				default:                 out_user_q[2:1] <= APPLIED_BYPASS;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_user_q;

	`ISD_ASSERT_NXT(a_busy_after_accept, in_fire, (state_q != ST_IDLE), "idle after accept")
	`ISD_ASSERT_IMP(a_sweep_in_row, sw_v_s1, (({1'b0, sw_a_s1}) < w), "sweep past row end")
	`ISD_ASSERT_IMP(a_pending_bound, 1'b1, (pc_q <= WW'(MAX_WIDTH)), "pending count overflow")
	`ISD_ASSERT_NXT(a_emit_counts, out_load, (pc_q == $past(pc_q) - WW'(1)), "pending count slip")
endmodule
